### design/salsa20_stream_cipher_core_assert.svh
// Assertion macros for the Salsa20 stream cipher core.
// Expects signals named clock and reset in the including scope.
`ifndef SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define SALSA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("salsa20 core: assertion failed");

// next-cycle implication
`define SALSA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("salsa20 core: assertion failed");

`endif

### design/salsa_pkg.sv
// Shared types, constants and functions of the Salsa20 stream cipher core.
// No dependencies.
package salsa_pkg;

   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646E;
   localparam logic [31:0] SIGMA2 = 32'h7962_2D32;
   localparam logic [31:0] SIGMA3 = 32'h6B20_6574;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DR_W      = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MID_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MID_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_CTR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DOUBLE_RNDS  = 3'd6;

   localparam logic [DR_W-1:0] DR_RESET = 5'd10;

   typedef logic [31:0] word_type;
   typedef word_type blk_type [16];

   // word indexes (a, b, c, d) of the four quarter-rounds
   localparam logic [3:0] COL_IDX [4][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1 },
      '{4'd10, 4'd14, 4'd2,  4'd6 },
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };
   localparam logic [3:0] ROW_IDX [4][4] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3 },
      '{4'd5,  4'd6,  4'd7,  4'd4 },
      '{4'd10, 4'd11, 4'd8,  4'd9 },
      '{4'd15, 4'd12, 4'd13, 4'd14}
   };

   // controller -> datapath
   typedef struct packed {
      logic       accept;  // latch input beat
      logic       load;    // load working state from key/nonce/counter
      logic       round;   // one quarter-round step on all four lanes
      logic       row;     // 0 = column round, 1 = row round
      logic [1:0] step;    // step within the quarter-round
      logic       finish;  // add input state back, store keystream block
      logic       emit;    // load output register, advance position
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic            need_refill;
      logic [DR_W-1:0] double_rounds;
   } sts_type;

   // rotate left by the step's constant (7, 9, 13, 18)
   function automatic word_type qr_rotl(input word_type v, input logic [1:0] step);
      word_type r;
      case (step)
         2'd0:    r = {v[24:0], v[31:25]};
         2'd1:    r = {v[22:0], v[31:23]};
         2'd2:    r = {v[18:0], v[31:19]};
         2'd3:    r = {v[13:0], v[31:14]};
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic blk_type build_state(input logic [63:0] k0, input logic [63:0] k1,
                                           input logic [63:0] k2, input logic [63:0] k3,
                                           input logic [63:0] nonce,
                                           input logic [63:0] ctr);
      blk_type s;
      s[0]  = SIGMA0;
      s[1]  = k0[31:0];
      s[2]  = k0[63:32];
      s[3]  = k1[31:0];
      s[4]  = k1[63:32];
      s[5]  = SIGMA1;
      s[6]  = nonce[31:0];
      s[7]  = nonce[63:32];
      s[8]  = ctr[31:0];
      s[9]  = ctr[63:32];
      s[10] = SIGMA2;
      s[11] = k2[31:0];
      s[12] = k2[63:32];
      s[13] = k3[31:0];
      s[14] = k3[63:32];
      s[15] = SIGMA3;
      return s;
   endfunction

endpackage

### design/salsa_ctrl.sv
// Salsa20 core controller: byte sequencing and round counting.
// Depends on salsa_pkg.
module salsa_ctrl
   import salsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type       state_ff;
   logic [1:0]      step_ff;
   logic            row_ff;
   logic [DR_W-1:0] dr_ff;
   logic            rsp_valid_ff;
   logic            out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_tvalid;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.round  = (state_ff == ST_ROUND);
      cmd.row    = row_ff;
      cmd.step   = step_ff;
      cmd.finish = (state_ff == ST_FINISH);
      cmd.emit   = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         row_ff       <= 1'b0;
         dr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= sts.need_refill ? ST_LOAD : ST_EMIT;
               end
            end
            ST_LOAD: begin
               step_ff  <= 2'd0;
               row_ff   <= 1'b0;
               dr_ff    <= '0;
               state_ff <= (sts.double_rounds == '0) ? ST_FINISH : ST_ROUND;
            end
            ST_ROUND: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  row_ff <= !row_ff;
                  if (row_ff) begin
                     dr_ff <= dr_ff + DR_W'(1);
                     if (dr_ff + DR_W'(1) == sts.double_rounds) begin
                        state_ff <= ST_FINISH;
                     end
                  end
               end
            end
            ST_FINISH: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### design/salsa_datapath.sv
// Salsa20 core datapath: config registers, working state, keystream block,
// output register. Depends on salsa_pkg.
module salsa_datapath
   import salsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic [7:0]           out_byte,
   output logic                 out_last
);

   logic [63:0]     key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff, start_ff;
   logic [DR_W-1:0] dr_ff;

   logic [63:0] blk_ff;     // counter of the block now in use
   logic        mid_ff;
   logic [5:0]  pos_ff;
   logic [7:0]  data_ff;
   logic        last_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   word_type w_ff  [16];
   word_type ks_ff [16];
   blk_type  w_in;
   blk_type  load_blk;
   blk_type  fin_blk;
   logic [63:0] ctr_in;
   word_type    ks_word;
   logic [7:0]  ks_byte;

   assign ctr_in   = mid_ff ? blk_ff + 64'd1 : start_ff;
   assign load_blk = build_state(key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff, ctr_in);
   assign fin_blk  = build_state(key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff, blk_ff);

   // one add-rotate-xor per quarter-round lane
   always_comb begin
      logic [1:0] s_dst;
      logic [1:0] s_src;
      logic [3:0] dst;
      logic [3:0] src1;
      logic [3:0] src2;
      s_dst = cmd.step + 2'd1;
      s_src = cmd.step + 2'd3;
      w_in  = w_ff;
      for (int q = 0; q < 4; q++) begin
         dst  = cmd.row ? ROW_IDX[q][s_dst]    : COL_IDX[q][s_dst];
         src1 = cmd.row ? ROW_IDX[q][cmd.step] : COL_IDX[q][cmd.step];
         src2 = cmd.row ? ROW_IDX[q][s_src]    : COL_IDX[q][s_src];
         w_in[dst] = w_ff[dst] ^ qr_rotl(w_ff[src1] + w_ff[src2], cmd.step);
      end
   end

   assign ks_word = ks_ff[pos_ff[5:2]];
   assign ks_byte = ks_word[{pos_ff[1:0], 3'b000} +: 8];

   assign sts.need_refill   = !mid_ff || (pos_ff == 6'd0);
   assign sts.double_rounds = dr_ff;
   assign out_byte          = out_byte_ff;
   assign out_last          = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff  <= '0;
         key1_ff  <= '0;
         key2_ff  <= '0;
         key3_ff  <= '0;
         nonce_ff <= '0;
         start_ff <= '0;
         dr_ff    <= DR_RESET;
         mid_ff   <= 1'b0;
         pos_ff   <= 6'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_KEY_LOW:      key0_ff  <= csr_wdata;
               REG_KEY_MID_LOW:  key1_ff  <= csr_wdata;
               REG_KEY_MID_HIGH: key2_ff  <= csr_wdata;
               REG_KEY_HIGH:     key3_ff  <= csr_wdata;
               REG_NONCE:        nonce_ff <= csr_wdata;
               REG_START_CTR:    start_ff <= csr_wdata;
               REG_DOUBLE_RNDS:  dr_ff    <= csr_wdata[DR_W-1:0];
               default:          ;
            endcase
         end
         if (cmd.emit) begin
            if (last_ff) begin
               mid_ff <= 1'b0;
               pos_ff <= 6'd0;
            end else begin
               mid_ff <= 1'b1;
               pos_ff <= pos_ff + 6'd1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= in_byte;
         last_ff <= in_last;
      end
      if (cmd.load) begin
         blk_ff <= ctr_in;
         w_ff   <= load_blk;
      end else if (cmd.round) begin
         w_ff <= w_in;
      end
      if (cmd.finish) begin
         for (int i = 0; i < 16; i++) begin
            ks_ff[i] <= w_ff[i] + fin_blk[i];
         end
      end
      if (cmd.emit) begin
         out_byte_ff <= data_ff ^ ks_byte;
         out_last_ff <= last_ff;
      end
   end

endmodule

### design/salsa20_stream_cipher_core.sv
// Salsa20 stream cipher core, top level: controller plus datapath.
// Depends on salsa_pkg, salsa_ctrl, salsa_datapath and the assertion header.
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   req_tdata[7:0] data byte, req_tlast end of message
//   rsp      out  rsp_tvalid/rsp_tready   rsp_tdata[7:0] out byte,  rsp_tlast end of message
//   csr      in   csr_we                  csr_index (register), csr_wdata (64 bits)
//
// A byte inside a block passes the accept beat, then the output load.
// A byte that opens a block (first of a message, or every 64th) goes through accept,
// load, the rounds, final add and output load, with one add-rotate-xor step on each of
// the four quarter-round lanes per cycle, 8 steps per double round.
// Reset is synchronous, active high; config resets to zero with 10 double rounds.
// A new beat is taken while the previous result still waits in the output register;
// the core stalls in its output state only when that register is still full.
`include "salsa20_stream_cipher_core_assert.svh"

module salsa20_stream_cipher_core
   import salsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input beats
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // message_end
   // result beats
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_byte
   output logic                 rsp_tlast,   // out_last
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   salsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   salsa_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .cmd       (cmd),
      .sts       (sts),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // an accepted beat leaves the core busy in the following cycle
   `SALSA_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // an output load always presents a result next cycle
   `SALSA_ASSERT_NXT(a_emit_gives_valid, cmd.emit, rsp_tvalid)
   // a result appears only from an output load
   `SALSA_ASSERT_NOW(a_valid_from_emit, $rose(rsp_tvalid), $past(cmd.emit))

endmodule

### tb/salsa20_stream_cipher_core_tb.sv
// Self-checking testbench for the Salsa20 stream cipher core.
// Holds its own keystream predictor; needs salsa_pkg and salsa20_stream_cipher_core.
`timescale 1ns / 1ps

module salsa20_stream_cipher_core_tb
   import salsa_pkg::*;
;

   // ---------------------------------------------------------------------
   // run sizing
   // ---------------------------------------------------------------------
   localparam int RAND_ITEMS   = 1100;
   localparam int QUIET_TAIL   = 150;       // phases starting in the last beats run with no idling at all
   localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
   localparam int SETTLE       = 300;       // longer than the slowest block refill
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int MAX_PRINTS   = 50;

   // index with no register behind it; the core must drop such writes
   localparam logic [CSR_IDX_W-1:0] IDX_UNUSED = 3'd7;

   // "expa" "nd 3" "2-by" "te k"
   localparam logic [31:0] SIG_0 = 32'h6170_7865;
   localparam logic [31:0] SIG_1 = 32'h3320_646E;
   localparam logic [31:0] SIG_2 = 32'h7962_2D32;
   localparam logic [31:0] SIG_3 = 32'h6B20_6574;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } out_beat_type;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [63:0]            val;
      logic [7:0]             data;
      logic                   last;
      bit                     known;   // want is typed in, not predicted
      logic [7:0]             want;
   } dir_row_type;

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] data_byte
   logic                 req_tlast;   // message_end
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [7:0]           rsp_tdata;   // [7:0] out_byte
   logic                 rsp_tlast;   // out_last
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;

   salsa20_stream_cipher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor state: a shadow of the registers plus the keystream position
   // ---------------------------------------------------------------------
   logic [63:0] cfg_key [4];
   logic [63:0] cfg_nonce;
   logic [63:0] cfg_start;
   logic [4:0]  cfg_drounds;

   word_type    key_stream [16];
   word_type    mix [16];        // working block during a refill
   logic [5:0]  stream_pos;
   logic [63:0] blk_ctr;
   logic        msg_open;

   out_beat_type expected_out [$];
   dir_row_type  dir_rows [$];

   int          mismatches;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_request;

   function automatic word_type rotl32(input word_type v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void quarter_round(input int a, input int b, input int c, input int d);
      mix[b] = mix[b] ^ rotl32(mix[a] + mix[d], 7);
      mix[c] = mix[c] ^ rotl32(mix[b] + mix[a], 9);
      mix[d] = mix[d] ^ rotl32(mix[c] + mix[b], 13);
      mix[a] = mix[a] ^ rotl32(mix[d] + mix[c], 18);
   endfunction

   // one 64-byte block from the current key, nonce and block counter
   function automatic void make_key_block();
      word_type base [16];
      int       r;
      int       i;
      base[0]  = SIG_0;
      base[1]  = cfg_key[0][31:0];
      base[2]  = cfg_key[0][63:32];
      base[3]  = cfg_key[1][31:0];
      base[4]  = cfg_key[1][63:32];
      base[5]  = SIG_1;
      base[6]  = cfg_nonce[31:0];
      base[7]  = cfg_nonce[63:32];
      base[8]  = blk_ctr[31:0];
      base[9]  = blk_ctr[63:32];
      base[10] = SIG_2;
      base[11] = cfg_key[2][31:0];
      base[12] = cfg_key[2][63:32];
      base[13] = cfg_key[3][31:0];
      base[14] = cfg_key[3][63:32];
      base[15] = SIG_3;
      for (i = 0; i < 16; i++) mix[i] = base[i];
      for (r = 0; r < int'(cfg_drounds); r++) begin
         // columns
         quarter_round(0, 4, 8, 12);
         quarter_round(5, 9, 13, 1);
         quarter_round(10, 14, 2, 6);
         quarter_round(15, 3, 7, 11);
         // rows
         quarter_round(0, 1, 2, 3);
         quarter_round(5, 6, 7, 4);
         quarter_round(10, 11, 8, 9);
         quarter_round(15, 12, 13, 14);
      end
      for (i = 0; i < 16; i++) key_stream[i] = mix[i] + base[i];
   endfunction

   // ciphertext byte for one accepted input beat; advances the stream state
   function automatic logic [7:0] cipher_byte(input logic [7:0] d, input logic l);
      logic [5:0] p;
      word_type   w;
      logic [7:0] ks;
      if (!msg_open) begin
         blk_ctr    = cfg_start;
         stream_pos = 6'd0;
      end
      if (stream_pos == 6'd0) begin
         make_key_block();
         blk_ctr = blk_ctr + 64'd1;   // wraps mod 2^64
      end
      p  = stream_pos;
      w  = key_stream[p[5:2]];
      ks = w[8 * p[1:0] +: 8];
      if (l) begin
         msg_open   = 1'b0;
         stream_pos = 6'd0;
      end else begin
         msg_open   = 1'b1;
         stream_pos = p + 6'd1;
      end
      return d ^ ks;
   endfunction

   function automatic void shadow_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      case (idx)
         REG_KEY_LOW:      cfg_key[0] = val;
         REG_KEY_MID_LOW:  cfg_key[1] = val;
         REG_KEY_MID_HIGH: cfg_key[2] = val;
         REG_KEY_HIGH:     cfg_key[3] = val;
         REG_NONCE:        cfg_nonce = val;
         REG_START_CTR:    cfg_start = val;
         REG_DOUBLE_RNDS:  cfg_drounds = val[4:0];
         default: ;        // unmapped index: dropped
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // directed table builders
   // ---------------------------------------------------------------------
   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      dir_row_type r;
      r = '{kind: ROW_WRITE, idx: idx, val: val, data: 8'h00, last: 1'b0,
            known: 1'b0, want: 8'h00};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_beat(input logic [7:0] d, input logic l);
      dir_row_type r;
      r = '{kind: ROW_BEAT, idx: '0, val: '0, data: d, last: l, known: 1'b0, want: 8'h00};
      dir_rows.push_back(r);
   endfunction

   function automatic void add_known(input logic [7:0] d, input logic l, input logic [7:0] w);
      dir_row_type r;
      r = '{kind: ROW_BEAT, idx: '0, val: '0, data: d, last: l, known: 1'b1, want: w};
      dir_rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // mismatch reporting
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < MAX_PRINTS)
         $display("mismatch @%0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------
   // register write at the next edge; the caller's next beat drops csr_we
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      shadow_reg(idx, val);
   endtask

   // offer one beat (after an optional idle burst) and wait for the handshake
   task automatic send_byte(input logic [7:0] d, input logic l, input bit known,
                            input logic [7:0] want);
      out_beat_type e;
      logic [7:0]   pred;
      csr_we <= 1'b0;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      // beat taken at this edge
      pred   = cipher_byte(d, l);
      e.data = known ? want : pred;
      e.last = l;
      expected_out.push_back(e);
   endtask

   // stop offering and wait until every result is back; core is idle after
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // receiver side: random back-pressure, plus one long hold on request
   // ---------------------------------------------------------------------
   initial begin
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result checker: every result beat against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      out_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            report_mismatch("unexpected beat, data", 64'(rsp_tdata), 64'd0);
         end else begin
            e = expected_out.pop_front();
            if (rsp_tdata !== e.data)
               report_mismatch("out_byte", 64'(rsp_tdata), 64'(e.data));
            if (rsp_tlast !== e.last)
               report_mismatch("out_last", 64'(rsp_tlast), 64'(e.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      dir_row_type row;
      int          i;
      int          phase;
      int          rand_sent;
      int          budget;
      int          len;
      int          j;
      int          pick;
      logic [63:0] val;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;

      mismatches    = 0;
      cycle_count   = 0;
      hold_request  = 1'b0;
      send_idle_pct = 10;
      recv_idle_pct = 10;

      // predictor at its reset point
      for (i = 0; i < 4; i++) cfg_key[i] = '0;
      cfg_nonce   = '0;
      cfg_start   = '0;
      cfg_drounds = 5'd10;
      for (i = 0; i < 16; i++) key_stream[i] = '0;
      stream_pos  = '0;
      blk_ctr     = '0;
      msg_open    = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed table ---
      // all-zero key at the reset round count
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b1);
      // unmapped index must not reach the round count
      add_write(IDX_UNUSED, '1);
      // zero rounds: keystream is twice the start block, word 0 = 2 * sigma0
      add_write(REG_DOUBLE_RNDS, 64'd0);
      add_known(8'h00, 1'b0, 8'hCA);
      add_known(8'hFF, 1'b0, 8'h0F);
      add_known(8'h00, 1'b0, 8'hE0);
      add_known(8'h5A, 1'b1, 8'h98);
      // after message end the next byte restarts at byte 0 of a fresh block
      add_known(8'h00, 1'b1, 8'hCA);
      // all-ones key, nonce and start counter, one double round
      add_write(REG_KEY_LOW, '1);
      add_write(REG_KEY_MID_LOW, '1);
      add_write(REG_KEY_MID_HIGH, '1);
      add_write(REG_KEY_HIGH, '1);
      add_write(REG_NONCE, '1);
      add_write(REG_START_CTR, '1);
      add_write(REG_DOUBLE_RNDS, 64'd1);
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'hA5, 1'b1);
      // widest round count the 5-bit field holds
      add_write(REG_START_CTR, 64'd0);
      add_write(REG_DOUBLE_RNDS, 64'd31);
      add_beat(8'h3C, 1'b0);
      add_beat(8'hC3, 1'b1);
      // round count of 16, two single-byte messages
      add_write(REG_DOUBLE_RNDS, 64'd16);
      add_beat(8'h00, 1'b1);
      add_beat(8'hFF, 1'b1);
      // only the low five bits of the write count
      add_write(REG_DOUBLE_RNDS, 64'hFFFF_FFFF_FFFF_FFE3);
      add_beat(8'h11, 1'b1);

      for (i = 0; i < dir_rows.size(); i++) begin
         row = dir_rows[i];
         if (row.kind == ROW_WRITE) begin
            if (i > 0 && dir_rows[i - 1].kind == ROW_BEAT) drain_results();
            write_reg(row.idx, row.val);
         end else begin
            send_byte(row.data, row.last, row.known, row.want);
         end
      end

      // --- random phases ---
      // Each phase: drain, rewrite some registers, then a stream of messages.
      // A phase may stop inside a message, so the next writes land mid-message.
      rand_sent = 0;
      phase     = 0;
      while (rand_sent < RAND_ITEMS) begin
         drain_results();

         for (j = 0; j < 6; j++) begin
            if ($urandom_range(0, 2) == 0) begin
               val = {$urandom, $urandom};
               // start close to the top so long messages cross the counter wrap
               if (j == int'(REG_START_CTR) && $urandom_range(0, 2) == 0)
                  val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
               write_reg(j[CSR_IDX_W-1:0], val);
            end
         end
         pick = $urandom_range(0, 9);
         case (pick)
            0:       val = 64'd0;
            1:       val = 64'd31;
            2:       val = {$urandom, $urandom};
            default: val = 64'($urandom_range(1, 12));
         endcase
         write_reg(REG_DOUBLE_RNDS, val);
         if ($urandom_range(0, 5) == 0) write_reg(IDX_UNUSED, {$urandom, $urandom});

         if (rand_sent >= RAND_ITEMS - QUIET_TAIL) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            pick = $urandom_range(0, 2);
            send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
            pick = $urandom_range(0, 2);
            recv_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
         end

         budget = $urandom_range(40, 120);
         // second phase: receiver holds off while the sender keeps pushing
         if (phase == 1) begin
            hold_request  = 1'b1;
            send_idle_pct = 0;
            budget        = 120;
         end

         while (budget > 0 && rand_sent < RAND_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               len = 1;                          // single-byte messages
            else if (pick <= 2)
               len = $urandom_range(60, 140);    // usually crosses block boundaries
            else
               len = $urandom_range(1, 24);
            for (j = 0; j < len && budget > 0 && rand_sent < RAND_ITEMS; j++) begin
               send_byte(8'($urandom_range(0, 255)), (j == len - 1), 1'b0, 8'h00);
               budget--;
               rand_sent++;
            end
         end
         phase++;
      end

      // --- wind down ---
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_out.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/salsa_pkg.sv
design/salsa_ctrl.sv
design/salsa_datapath.sv
design/salsa20_stream_cipher_core.sv
tb/salsa20_stream_cipher_core_tb.sv
